// ===== sv/cmfuv_pkg.sv =====
package cmfuv_pkg;

   localparam int COORD_WIDTH_DEFAULT  = 16;
   localparam int UV_FRAC_BITS_DEFAULT = 16;
   localparam int FACE_CELL_WIDTH      = 4;

   localparam int FACES_X = 4;
   localparam int FACES_Y = 3;

   localparam logic [FACE_CELL_WIDTH-1:0] CELL_POS_X = FACE_CELL_WIDTH'(6);
   localparam logic [FACE_CELL_WIDTH-1:0] CELL_NEG_X = FACE_CELL_WIDTH'(4);
   localparam logic [FACE_CELL_WIDTH-1:0] CELL_POS_Y = FACE_CELL_WIDTH'(9);
   localparam logic [FACE_CELL_WIDTH-1:0] CELL_NEG_Y = FACE_CELL_WIDTH'(1);
   localparam logic [FACE_CELL_WIDTH-1:0] CELL_POS_Z = FACE_CELL_WIDTH'(5);
   localparam logic [FACE_CELL_WIDTH-1:0] CELL_NEG_Z = FACE_CELL_WIDTH'(7);

endpackage

// ===== sv/cmfuv_if.sv =====
interface cmfuv_req_if
   import cmfuv_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] normal_c0;
   logic signed [COORD_WIDTH-1:0] normal_c1;
   logic signed [COORD_WIDTH-1:0] normal_c2;

   modport source (output valid, output normal_c0, output normal_c1, output normal_c2,
                   input ready);
   modport sink   (input valid, input normal_c0, input normal_c1, input normal_c2,
                   output ready);
endinterface

interface cmfuv_rsp_if
   import cmfuv_pkg::*;
#(
   parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEFAULT
);
   logic                       valid;
   logic                       ready;
   logic [UV_FRAC_BITS:0]      tex_u;
   logic [UV_FRAC_BITS:0]      tex_v;
   logic [FACE_CELL_WIDTH-1:0] face_cell;
   logic                       zero_vector;

   modport source (output valid, output tex_u, output tex_v, output face_cell,
                   output zero_vector, input ready);
   modport sink   (input valid, input tex_u, input tex_v, input face_cell,
                   input zero_vector, output ready);
endinterface

// ===== sv/cube_map_face_uv_core.sv =====
// Channel   Dir  Payload                                       Handshake
// req_ch    in   normal_c0, normal_c1, normal_c2 (signed)      valid / ready
// rsp_ch    out  tex_u, tex_v, face_cell, zero_vector          valid / ready
//
// One request is taken per cycle unless every stage is full and rsp_ch.ready is low.
// The latency is set by the restoring dividers, which resolve one quotient bit per stage.
// Reset clears only the stage valid bits; payload registers are not reset.
// Each stage advances whenever its successor is empty or advancing, so bubbles close up
// and requests are still taken while a finished result waits on rsp_ch.ready, as long as some stage is empty.
module cube_map_face_uv_core
   import cmfuv_pkg::*;
#(
   parameter int COORD_WIDTH  = COORD_WIDTH_DEFAULT,
   parameter int UV_FRAC_BITS = UV_FRAC_BITS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   cmfuv_req_if.sink   req_ch,
   cmfuv_rsp_if.source rsp_ch
);

   localparam int CW = COORD_WIDTH;
   localparam int QW = UV_FRAC_BITS + 1;
   localparam int DW = COORD_WIDTH + 3;
   localparam int NW = COORD_WIDTH + 4;
   localparam int RW = COORD_WIDTH + 3 + UV_FRAC_BITS;

   localparam logic signed [CW-1:0] MIN_VAL = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0] MAX_VAL = ~MIN_VAL;

   typedef struct packed {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic [CW-1:0]        ax;
      logic [CW-1:0]        ay;
      logic [CW-1:0]        az;
   } axis_stage_type;

   typedef struct packed {
      logic [CW-1:0]                m;
      logic signed [CW:0]           uc;
      logic signed [CW:0]           vc;
      logic [FACE_CELL_WIDTH-1:0]   face_id;
      logic                         zero;
   } face_stage_type;

   typedef struct packed {
      logic [RW-1:0]              rem_u;
      logic [RW-1:0]              rem_v;
      logic [DW-1:0]              den_u;
      logic [DW-1:0]              den_v;
      logic [QW-1:0]              q_u;
      logic [QW-1:0]              q_v;
      logic [FACE_CELL_WIDTH-1:0] face_id;
      logic                       zero;
   } div_stage_type;

   axis_stage_type a_in, a_ff;
   face_stage_type b_in, b_ff;
   div_stage_type  c_in, c_ff;
   div_stage_type  d_ff [QW];
   logic           a_valid_ff, b_valid_ff, c_valid_ff;
   logic [QW-1:0]  d_valid_ff;
   logic [QW-1:0]  d_en;
   logic           a_en, b_en, c_en;

   assign c_en = !c_valid_ff || d_en[0];
   assign b_en = !b_valid_ff || c_en;
   assign a_en = !a_valid_ff || b_en;
   assign req_ch.ready = a_en && !reset;

   // Stage A: reorder the components, negate the third with saturation, and take magnitudes.
   always_comb begin
      a_in.x  = req_ch.normal_c1;
      a_in.y  = (req_ch.normal_c2 == MIN_VAL) ? MAX_VAL : -req_ch.normal_c2;
      a_in.z  = req_ch.normal_c0;
      a_in.ax = a_in.x[CW-1] ? (~a_in.x + 1'b1) : a_in.x;
      a_in.ay = a_in.y[CW-1] ? (~a_in.y + 1'b1) : a_in.y;
      a_in.az = a_in.z[CW-1] ? (~a_in.z + 1'b1) : a_in.z;
   end

   // Stage B: face selection; the later passing test overrides an earlier one.
   always_comb begin
      logic signed [CW:0] xs;
      logic signed [CW:0] ys;
      logic signed [CW:0] zs;
      xs = {a_ff.x[CW-1], a_ff.x};
      ys = {a_ff.y[CW-1], a_ff.y};
      zs = {a_ff.z[CW-1], a_ff.z};
      b_in.m       = '0;
      b_in.uc      = '0;
      b_in.vc      = '0;
      b_in.face_id = '0;
      if (a_ff.ax >= a_ff.ay && a_ff.ax >= a_ff.az) begin
         b_in.m  = a_ff.ax;
         b_in.vc = ys;
         if (a_ff.x > 0) begin
            b_in.uc      = -zs;
            b_in.face_id = CELL_POS_X;
         end else begin
            b_in.uc      = zs;
            b_in.face_id = CELL_NEG_X;
         end
      end
      if (a_ff.ay >= a_ff.ax && a_ff.ay >= a_ff.az) begin
         b_in.m  = a_ff.ay;
         b_in.uc = xs;
         if (a_ff.y > 0) begin
            b_in.vc      = -zs;
            b_in.face_id = CELL_POS_Y;
         end else begin
            b_in.vc      = zs;
            b_in.face_id = CELL_NEG_Y;
         end
      end
      if (a_ff.az >= a_ff.ax && a_ff.az >= a_ff.ay) begin
         b_in.m  = a_ff.az;
         b_in.vc = ys;
         if (a_ff.z > 0) begin
            b_in.uc      = xs;
            b_in.face_id = CELL_POS_Z;
         end else begin
            b_in.uc      = -xs;
            b_in.face_id = CELL_NEG_Z;
         end
      end
      b_in.zero = (b_in.m == '0);
      if (b_in.zero) begin
         b_in.m  = CW'(1);
         b_in.uc = '0;
         b_in.vc = '0;
      end
   end

   // Stage C: form the numerators and denominators of both quotients.
   always_comb begin
      logic [1:0]           col;
      logic [1:0]           row;
      logic [DW-1:0]        m_d;
      logic [DW-1:0]        m_col;
      logic [DW-1:0]        m_row;
      logic signed [NW-1:0] m_s;
      logic signed [NW-1:0] num_u_s;
      logic signed [NW-1:0] num_v_s;
      col     = 2'(b_ff.face_id % FACES_X);
      row     = 2'(b_ff.face_id / FACES_X);
      m_d     = DW'(b_ff.m);
      m_col   = m_d * DW'({col, 1'b0});
      m_row   = m_d * DW'({row, 1'b0});
      m_s     = signed'({4'b0000, b_ff.m});
      num_u_s = signed'({1'b0, m_col}) + NW'(b_ff.uc) + m_s;
      num_v_s = signed'({1'b0, m_row}) + NW'(b_ff.vc) + m_s;
      c_in.rem_u   = {num_u_s[DW-1:0], {UV_FRAC_BITS{1'b0}}};
      c_in.rem_v   = {num_v_s[DW-1:0], {UV_FRAC_BITS{1'b0}}};
      c_in.den_u   = m_d * DW'(2 * FACES_X);
      c_in.den_v   = m_d * DW'(2 * FACES_Y);
      c_in.q_u     = '0;
      c_in.q_v     = '0;
      c_in.face_id = b_ff.face_id;
      c_in.zero    = b_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (a_en) begin
            a_valid_ff <= req_ch.valid;
         end
         if (b_en) begin
            b_valid_ff <= a_valid_ff;
         end
         if (c_en) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_ff <= a_in;
      end
      if (b_en) begin
         b_ff <= b_in;
      end
      if (c_en) begin
         c_ff <= c_in;
      end
   end

   // Restoring dividers: stage gi decides quotient bit QW-1-gi for u and v.
   for (genvar gi = 0; gi < QW; gi++) begin : g_div
      localparam int SHIFT = QW - 1 - gi;
      div_stage_type src;
      div_stage_type d_in;
      logic          src_valid;
      logic [RW-1:0] sub_u, sub_v;
      logic [RW:0]   diff_u, diff_v;

      if (gi == 0) begin : g_first
         assign src       = c_ff;
         assign src_valid = c_valid_ff;
      end else begin : g_next
         assign src       = d_ff[gi-1];
         assign src_valid = d_valid_ff[gi-1];
      end

      if (gi == QW - 1) begin : g_last
         assign d_en[gi] = !d_valid_ff[gi] || rsp_ch.ready;
      end else begin : g_mid
         assign d_en[gi] = !d_valid_ff[gi] || d_en[gi+1];
      end

      always_comb begin
         sub_u  = RW'(src.den_u) << SHIFT;
         sub_v  = RW'(src.den_v) << SHIFT;
         diff_u = {1'b0, src.rem_u} - {1'b0, sub_u};
         diff_v = {1'b0, src.rem_v} - {1'b0, sub_v};
         d_in       = src;
         d_in.rem_u = diff_u[RW] ? src.rem_u : diff_u[RW-1:0];
         d_in.rem_v = diff_v[RW] ? src.rem_v : diff_v[RW-1:0];
         d_in.q_u   = {src.q_u[QW-2:0], !diff_u[RW]};
         d_in.q_v   = {src.q_v[QW-2:0], !diff_v[RW]};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d_valid_ff[gi] <= 1'b0;
         end else if (d_en[gi]) begin
            d_valid_ff[gi] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (d_en[gi]) begin
            d_ff[gi] <= d_in;
         end
      end
   end

   assign rsp_ch.valid       = d_valid_ff[QW-1];
   assign rsp_ch.tex_u       = d_ff[QW-1].q_u;
   assign rsp_ch.tex_v       = d_ff[QW-1].q_v;
   assign rsp_ch.face_cell   = d_ff[QW-1].face_id;
   assign rsp_ch.zero_vector = d_ff[QW-1].zero;

`ifndef SYNTHESIS
   localparam logic [QW-1:0] CENTER_U =
      QW'((2 * (CELL_NEG_Z % FACES_X) + 1) * (1 << UV_FRAC_BITS) / (2 * FACES_X));
   localparam logic [QW-1:0] CENTER_V =
      QW'((2 * (CELL_NEG_Z / FACES_X) + 1) * (1 << UV_FRAC_BITS) / (2 * FACES_Y));

   // A zero vector falls on the -Z face and reports that face's center.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.zero_vector |->
         rsp_ch.face_cell == CELL_NEG_Z && rsp_ch.tex_u == CENTER_U
         && rsp_ch.tex_v == CENTER_V)
      else $error("zero vector result is not the -Z face center");

   // The horizontal coordinate stays inside the column of the reported cell.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         int'(rsp_ch.tex_u) >= ((int'(rsp_ch.face_cell) % FACES_X) << UV_FRAC_BITS) / FACES_X
         && int'(rsp_ch.tex_u)
            <= (((int'(rsp_ch.face_cell) % FACES_X) + 1) << UV_FRAC_BITS) / FACES_X)
      else $error("tex_u lies outside the column of its face cell");

   // The vertical coordinate stays inside the row of the reported cell.
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |->
         int'(rsp_ch.tex_v) >= ((int'(rsp_ch.face_cell) / FACES_X) << UV_FRAC_BITS) / FACES_Y
         && int'(rsp_ch.tex_v)
            <= (((int'(rsp_ch.face_cell) / FACES_X) + 1) << UV_FRAC_BITS) / FACES_Y)
      else $error("tex_v lies outside the row of its face cell");
`endif

endmodule
